FILE: hdl/playfair_pkg.sv
// Shared types, constants and helper functions of the Playfair digraph encryptor.
package playfair_pkg;

    typedef enum logic [1:0] {
        OP_KEY_CHAR   = 2'd0,
        OP_FINISH_KEY = 2'd1,
        OP_TEXT_CHAR  = 2'd2,
        OP_END_TEXT   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NON_LETTER = 2'd1,
        ST_NOT_READY  = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        SEL_FIRST  = 2'd0,
        SEL_SECOND = 2'd1,
        SEL_STATUS = 2'd2
    } out_sel_t;

    localparam logic [4:0] IDX_I       = 5'd8;
    localparam logic [4:0] IDX_J       = 5'd9;
    localparam logic [4:0] IDX_X       = 5'd23;
    localparam logic [4:0] IDX_Z       = 5'd25;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [4:0] CELL_COUNT  = 5'd25;
    localparam logic [2:0] LAST_COORD  = 3'd4;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_A     = 8'h41;

    typedef struct packed {
        logic     accept;
        logic     walk;
        logic     read_pos;
        logic     read_sq;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic start_finish;
        logic start_pair;
        logic start_status;
        logic walk_last;
    } dp_status_t;

    // Step a row or column index by one with wrap-around.
    function automatic logic [2:0] coord_inc(input logic [2:0] c);
        return (c == LAST_COORD) ? 3'd0 : c + 3'd1;
    endfunction

    // Row-major cell number row * 5 + col.
    function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

FILE: hdl/playfair_datapath.sv
// Datapath of the Playfair encryptor: square memories, pair state and cipher lookup.
module playfair_datapath
    import playfair_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [1:0]  in_opcode,
    input  logic [7:0]  in_raw,
    output logic [15:0] out_data,
    output logic        out_last
);

    // Square storage: position of each letter as {row, col}, and letter of each cell.
    logic [5:0] pos_mem [26];
    logic [4:0] sq_mem  [25];

    logic [25:0]  present_reg;
    logic [4:0]   fill_count_reg;
    logic [2:0]   fill_row_reg;
    logic [2:0]   fill_col_reg;
    logic         ready_reg;
    logic [4:0]   walk_reg;
    logic [4:0]   pending_letter_reg;
    logic         pending_valid_reg;
    logic [7:0]   prev_raw_reg;
    logic         started_reg;
    logic [4:0]   pair_a_reg;
    logic [4:0]   pair_b_reg;
    status_code_t err_code_reg;
    logic [5:0]   pos_a_reg;
    logic [5:0]   pos_b_reg;
    logic [4:0]   sq_x_reg;
    logic [4:0]   sq_y_reg;

    opcode_t    op;
    logic       is_letter;
    logic       is_space;
    logic [4:0] li_raw;
    logic [4:0] li_map;
    logic       dup;
    logic       text_letter;
    logic       place_req;
    logic [4:0] place_li;
    logic       place_ok;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] addr_x, addr_y;

    assign op          = opcode_t'(in_opcode);
    assign is_letter   = (in_raw[7:5] == 3'b010 || in_raw[7:5] == 3'b011)
                         && in_raw[4:0] != 5'd0 && in_raw[4:0] <= 5'd26;
    assign is_space    = (in_raw == ASCII_SPACE);
    assign li_raw      = in_raw[4:0] - 5'd1;
    assign li_map      = (li_raw == IDX_J) ? IDX_I : li_raw;
    assign dup         = pending_valid_reg && started_reg && (in_raw == prev_raw_reg);
    assign text_letter = (op == OP_TEXT_CHAR) && ready_reg && !is_space && is_letter;

    assign status.start_finish = (op == OP_FINISH_KEY) && !ready_reg;
    assign status.start_pair   = (text_letter && pending_valid_reg)
                                 || ((op == OP_END_TEXT) && pending_valid_reg && ready_reg);
    assign status.start_status = (op == OP_TEXT_CHAR)
                                 && (!ready_reg || (!is_space && !is_letter));
    assign status.walk_last    = (walk_reg == LAST_LETTER);

    always_comb begin
        if (cmd.walk) begin
            place_li  = walk_reg;
            place_req = 1'b1;
        end else begin
            place_li  = li_map;
            place_req = cmd.accept && (op == OP_KEY_CHAR) && !ready_reg && is_letter;
        end
    end

    assign place_ok = place_req && (place_li != IDX_J) && !present_reg[place_li]
                      && (fill_count_reg != CELL_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg        <= '0;
            fill_count_reg     <= '0;
            fill_row_reg       <= '0;
            fill_col_reg       <= '0;
            ready_reg          <= 1'b0;
            walk_reg           <= '0;
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
            prev_raw_reg       <= '0;
            started_reg        <= 1'b0;
        end else begin
            if (place_ok) begin
                present_reg[place_li] <= 1'b1;
                fill_count_reg        <= fill_count_reg + 5'd1;
                fill_col_reg          <= coord_inc(fill_col_reg);
                if (fill_col_reg == LAST_COORD) begin
                    fill_row_reg <= fill_row_reg + 3'd1;
                end
            end
            if (cmd.walk) begin
                walk_reg <= walk_reg + 5'd1;
                if (status.walk_last) begin
                    ready_reg <= 1'b1;
                end
            end
            if (cmd.accept) begin
                case (op)
                    OP_FINISH_KEY: begin
                        walk_reg <= '0;
                    end
                    OP_TEXT_CHAR: begin
                        if (ready_reg && (is_space || is_letter)) begin
                            prev_raw_reg <= in_raw;
                            started_reg  <= 1'b1;
                        end
                        if (text_letter) begin
                            if (dup || !pending_valid_reg) begin
                                pending_letter_reg <= li_map;
                                pending_valid_reg  <= 1'b1;
                            end else begin
                                pending_valid_reg  <= 1'b0;
                            end
                        end
                    end
                    OP_END_TEXT: begin
                        pending_letter_reg <= '0;
                        pending_valid_reg  <= 1'b0;
                        prev_raw_reg       <= '0;
                        started_reg        <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Pair capture and memory ports; payload only, no reset.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pair_a_reg   <= pending_letter_reg;
            pair_b_reg   <= (op == OP_END_TEXT) ? IDX_Z : (dup ? IDX_X : li_map);
            err_code_reg <= ready_reg ? ST_NON_LETTER : ST_NOT_READY;
        end
        if (place_ok) begin
            pos_mem[place_li]      <= {fill_row_reg, fill_col_reg};
            sq_mem[fill_count_reg] <= place_li;
        end
        if (cmd.read_pos) begin
            pos_a_reg <= pos_mem[pair_a_reg];
            pos_b_reg <= pos_mem[pair_b_reg];
        end
        if (cmd.read_sq) begin
            sq_x_reg <= sq_mem[addr_x];
            sq_y_reg <= sq_mem[addr_y];
        end
    end

    assign ra = pos_a_reg[5:3];
    assign ca = pos_a_reg[2:0];
    assign rb = pos_b_reg[5:3];
    assign cb = pos_b_reg[2:0];

    // Same row shifts right, same column shifts down, otherwise swap columns.
    always_comb begin
        if (ra == rb) begin
            addr_x = cell_addr(ra, coord_inc(ca));
            addr_y = cell_addr(rb, coord_inc(cb));
        end else if (ca == cb) begin
            addr_x = cell_addr(coord_inc(ra), ca);
            addr_y = cell_addr(coord_inc(rb), cb);
        end else begin
            addr_x = cell_addr(ra, cb);
            addr_y = cell_addr(rb, ca);
        end
    end

    always_comb begin
        case (cmd.out_sel)
            SEL_FIRST: begin
                out_data = {6'b0, ST_OK, ASCII_A + {3'b000, sq_x_reg}};
                out_last = 1'b0;
            end
            SEL_SECOND: begin
                out_data = {6'b0, ST_OK, ASCII_A + {3'b000, sq_y_reg}};
                out_last = 1'b1;
            end
            default: begin
                out_data = {6'b0, err_code_reg, 8'h00};
                out_last = 1'b1;
            end
        endcase
    end

endmodule

FILE: hdl/playfair_ctrl.sv
// Controller state machine of the Playfair encryptor.
module playfair_ctrl
    import playfair_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FINISH,
        S_LOOKUP,
        S_ADDR,
        S_OUT0,
        S_OUT1,
        S_OUTS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.walk     = 1'b0;
        cmd.read_pos = 1'b0;
        cmd.read_sq  = 1'b0;
        cmd.out_sel  = SEL_STATUS;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.start_finish) begin
                        state_next = S_FINISH;
                    end else if (status.start_pair) begin
                        state_next = S_LOOKUP;
                    end else if (status.start_status) begin
                        state_next = S_OUTS;
                    end
                end
            end
            S_FINISH: begin
                cmd.walk = 1'b1;
                if (status.walk_last) begin
                    state_next = S_IDLE;
                end
            end
            S_LOOKUP: begin
                cmd.read_pos = 1'b1;
                state_next   = S_ADDR;
            end
            S_ADDR: begin
                cmd.read_sq = 1'b1;
                state_next  = S_OUT0;
            end
            S_OUT0: begin
                cmd.out_sel = SEL_FIRST;
                m_tvalid    = 1'b1;
                if (m_tready) begin
                    state_next = S_OUT1;
                end
            end
            S_OUT1: begin
                cmd.out_sel = SEL_SECOND;
                m_tvalid    = 1'b1;
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            S_OUTS: begin
                cmd.out_sel = SEL_STATUS;
                m_tvalid    = 1'b1;
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/playfair_digraph_encryptor.sv
// Top level of the Playfair digraph encryptor: controller plus datapath.
//
//  Channel | Direction | tdata (low bit up)                  | tuser  | tlast
//  s_      | input     | raw_char[7:0]                       | opcode | -
//  m_      | output    | cipher_char[7:0], status[9:8], zero | -      | last_of_run
//
// A key character needs only the accept state; finish key is accepted, then walks A..Z.
// A closed pair passes through accept, position lookup, square read and an output state
// per cipher letter; a rejected item passes through accept and one status output.
// The synchronous active-low reset clears all control state and the present bits.
// The input is not ready while a result transfer is pending, and a stalled
// output holds its data steady.
module playfair_digraph_encryptor
    import playfair_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // raw_char[7:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // cipher_char[7:0], status[9:8], zero fill[15:10]
    output logic        m_tlast    // last_of_run
);

    // Commands from the controller and decoded item status from the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    playfair_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath decodes the item presented on the input; it only updates
    // its state on the controller's commands (the transfer, the key walk and the reads).
    playfair_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_opcode (s_tuser),
        .in_raw    (s_tdata),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: hdl/playfair_checker.sv
// Port-level assertions for the Playfair encryptor and their bind.
module playfair_checker
    import playfair_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // No new item is taken while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // The first letter of a pair is always followed at once by the second.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second cipher letter missing");

    // Error results carry no letter and close the run.
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != ST_OK |-> m_tdata[7:0] == 8'h00 && m_tlast)
        else $error("malformed error result");

    // Good results are upper-case letters other than J.
    a_letter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] == ST_OK |->
            m_tdata[7:0] >= 8'h41 && m_tdata[7:0] <= 8'h5A && m_tdata[7:0] != 8'h4A)
        else $error("cipher letter out of range");

endmodule

bind playfair_digraph_encryptor playfair_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/playfair_cipher_checker.sv
// Checker for the Playfair encryptor: predicts cipher results and compares each transfer.
`timescale 1ns / 1ps

module playfair_cipher_checker
    import playfair_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          letters_due
);

    typedef struct packed {
        logic [7:0]   ch;
        logic         last;
        status_code_t st;
    } cipher_result_t;

    cipher_result_t cipher_due_q[$];
    cipher_result_t want;
    int             errors;

    // Shadow copy of the square and the pairing state.
    logic [4:0] sq_cell [0:24];
    logic [4:0] cell_of [0:25];
    logic       placed  [0:25];
    int         filled;
    logic       key_done;
    logic [4:0] held_letter;
    logic       held_valid;
    logic [7:0] last_raw;
    logic       raw_seen;

    function automatic int letter_of(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 8'h61;
        if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 8'h41;
        return 26;
    endfunction

    function automatic void clear_square();
        for (int i = 0; i < 25; i++) sq_cell[i] = '0;
        for (int i = 0; i < 26; i++) begin
            cell_of[i] = '0;
            placed[i]  = 1'b0;
        end
        filled      = 0;
        key_done    = 1'b0;
        held_letter = '0;
        held_valid  = 1'b0;
        last_raw    = '0;
        raw_seen    = 1'b0;
    endfunction

    function automatic void place(input int li);
        if (li >= 26 || li == int'(IDX_J) || placed[li] || filled >= 25) return;
        placed[li]      = 1'b1;
        cell_of[li]     = 5'(filled);
        sq_cell[filled] = 5'(li);
        filled++;
    endfunction

    function automatic logic [7:0] cell_letter(input int r, input int c);
        return ASCII_A + {3'b000, sq_cell[(r % 5) * 5 + (c % 5)]};
    endfunction

    function automatic void push_result(input logic [7:0] ch, input logic last,
                                        input status_code_t st);
        cipher_result_t r;
        r.ch   = ch;
        r.last = last;
        r.st   = st;
        cipher_due_q.push_back(r);
    endfunction

    // Same row shifts right, same column shifts down, otherwise the corners swap.
    function automatic void encrypt_pair(input logic [4:0] a, input logic [4:0] b);
        int pa, pb, ra, ca, rb, cb;
        pa = int'(cell_of[a]);
        pb = int'(cell_of[b]);
        ra = pa / 5;
        ca = pa % 5;
        rb = pb / 5;
        cb = pb % 5;
        if (ra == rb) begin
            push_result(cell_letter(ra, ca + 1), 1'b0, ST_OK);
            push_result(cell_letter(rb, cb + 1), 1'b1, ST_OK);
        end else if (ca == cb) begin
            push_result(cell_letter(ra + 1, ca), 1'b0, ST_OK);
            push_result(cell_letter(rb + 1, cb), 1'b1, ST_OK);
        end else begin
            push_result(cell_letter(ra, cb), 1'b0, ST_OK);
            push_result(cell_letter(rb, ca), 1'b1, ST_OK);
        end
    endfunction

    function automatic void encrypt_item(input opcode_t op, input logic [7:0] raw);
        int li;
        case (op)
            OP_KEY_CHAR: begin
                if (!key_done) begin
                    li = letter_of(raw);
                    if (li == int'(IDX_J)) li = int'(IDX_I);
                    place(li);
                end
            end
            OP_FINISH_KEY: begin
                if (!key_done) begin
                    for (int i = 0; i < 26; i++) place(i);
                    key_done = 1'b1;
                end
            end
            OP_TEXT_CHAR: begin
                li = letter_of(raw);
                if (!key_done) begin
                    push_result(8'h00, 1'b1, ST_NOT_READY);
                end else if (raw == ASCII_SPACE) begin
                    last_raw = raw;
                    raw_seen = 1'b1;
                end else if (li >= 26) begin
                    push_result(8'h00, 1'b1, ST_NON_LETTER);
                end else begin
                    // A repeated raw byte closes the open pair with X first.
                    if (held_valid && raw_seen && raw == last_raw) begin
                        encrypt_pair(held_letter, IDX_X);
                        held_valid = 1'b0;
                    end
                    if (li == int'(IDX_J)) li = int'(IDX_I);
                    if (held_valid) begin
                        held_valid = 1'b0;
                        encrypt_pair(held_letter, 5'(li));
                    end else begin
                        held_letter = 5'(li);
                        held_valid  = 1'b1;
                    end
                    last_raw = raw;
                    raw_seen = 1'b1;
                end
            end
            default: begin
                if (held_valid && key_done) encrypt_pair(held_letter, IDX_Z);
                held_valid  = 1'b0;
                held_letter = '0;
                last_raw    = '0;
                raw_seen    = 1'b0;
            end
        endcase
    endfunction

    initial begin
        errors = 0;
        clear_square();
    end

    // Inputs are handled before outputs; a result never leaves on the edge
    // that accepts its own item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_square();
            cipher_due_q.delete();
        end else begin
            if (s_tvalid && s_tready) encrypt_item(opcode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                if (cipher_due_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result char=%h last=%b status=%0d, expected none",
                             $time, m_tdata[7:0], m_tlast, m_tdata[9:8]);
                end else begin
                    want = cipher_due_q.pop_front();
                    if (m_tdata[7:0] !== want.ch || m_tlast !== want.last
                            || m_tdata[9:8] !== want.st) begin
                        errors++;
                        $display("%0t: expected char=%h last=%b status=%0d,",
                                 $time, want.ch, want.last, want.st,
                                 " actual char=%h last=%b status=%0d",
                                 m_tdata[7:0], m_tlast, m_tdata[9:8]);
                    end
                end
            end
        end
        letters_due    <= cipher_due_q.size();
        mismatch_count <= errors;
    end

endmodule

FILE: tb/tb_playfair_digraph_encryptor.sv
// Testbench top for the Playfair encryptor: stimulus, flow control and the verdict.
`timescale 1ns / 1ps

module tb_playfair_digraph_encryptor;
    import playfair_pkg::*;

    localparam int          RANDOM_ITEMS = 850;
    localparam int          CALM_ITEMS   = 120;   // final stretch without any idling
    localparam int          LONG_HOLD    = 250;   // receiver hold-off in cycles
    localparam int          LIMIT_CYCLES = 300000;
    localparam logic [7:0]  LOWER_A      = 8'h61;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = OP_KEY_CHAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int          mismatch_count;
    int          letters_due;
    int          cycle_count = 0;
    logic        calm        = 1'b0;   // set for the last part of the run
    int          hold_asked  = 0;      // bumped by the stimulus to request a hold-off
    int          hold_taken  = 0;
    logic [7:0]  prev_text   = 8'h41;  // last text byte sent, for repeats

    always #5 aclk = ~aclk;

    playfair_digraph_encryptor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    playfair_cipher_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .letters_due    (letters_due)
    );

    // Watchdog. The slowest legal run is far below this limit: every item
    // waiting out a full sender gap, the key walk, and two results each held
    // by the longest receiver stall.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver side. Ready is held high for random stretches and dropped for
    // random bursts. When the stimulus asks for it, ready stays low for a long
    // stretch so that the block fills up and stalls its input.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (hold_asked != hold_taken) begin
                hold_taken = hold_asked;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                if (!calm && $urandom_range(0, 1) == 1) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge aclk);
                end
            end
        end
    end

    // Offer one item and hold it until the block takes it. Valid is left
    // high so that back-to-back transfers need no extra edge. Outside the
    // final stretch a random idle burst may come first; its data is junk.
    task automatic offer_item(input opcode_t op, input logic [7:0] ch);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 2'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= ch;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_TEXT_CHAR) prev_text = ch;
    endtask

    task automatic offer_string(input opcode_t op, input string s);
        for (int i = 0; i < s.len(); i++) offer_item(op, s[i]);
    endtask

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? ASCII_A : LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    initial begin
        int       pick;
        int       sent;
        opcode_t  op;
        logic [7:0] ch;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Text before the square is complete is refused with a status.
        offer_item(OP_TEXT_CHAR, "A");
        offer_item(OP_END_TEXT, 8'h00);

        // The key gives the square PLAYF / IREXM / BCDGH / KNOQS / TUVWZ.
        // It mixes case, folds J into I, and carries a non-letter, a repeated
        // letter and an all-ones byte that must be ignored.
        offer_string(OP_KEY_CHAR, "pLaY!fjreAxm");
        offer_item(OP_KEY_CHAR, 8'hFF);
        offer_item(OP_FINISH_KEY, 8'h00);
        // Key items once the square is done change nothing.
        offer_item(OP_KEY_CHAR, "q");
        offer_item(OP_FINISH_KEY, 8'h00);

        // Same row (PL), same column with J folded (Pj), rectangle (pr),
        // a doubled raw byte that inserts X (LL), then a pair of equal
        // letters whose raw bytes differ in case (Ll).
        offer_string(OP_TEXT_CHAR, "PLPjprLLl7");
        // Non-letters are rejected; a space is skipped silently.
        offer_item(OP_TEXT_CHAR, 8'hFF);
        offer_item(OP_TEXT_CHAR, 8'h00);
        offer_string(OP_TEXT_CHAR, " x");
        // End of text pads the lone X with Z; a second end finds nothing open.
        offer_item(OP_END_TEXT, 8'h00);
        offer_item(OP_END_TEXT, 8'h00);

        // Random text, with key items thrown in that the block ignores.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (sent == 300) hold_asked = hold_asked + 1;
            if (sent == 500) begin
                // Let every expected transfer drain before going on.
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (letters_due != 0);
            end
            pick = $urandom_range(0, 99);
            op   = OP_TEXT_CHAR;
            if (pick < 15) begin
                ch = prev_text;
            end else if (pick < 65) begin
                ch = any_letter();
            end else if (pick < 72) begin
                ch = ASCII_SPACE;
            end else if (pick < 80) begin
                ch = 8'($urandom);
            end else if (pick < 92) begin
                op = OP_END_TEXT;
                ch = 8'($urandom);
            end else if (pick < 97) begin
                op = OP_KEY_CHAR;
                ch = 8'($urandom);
            end else begin
                op = OP_FINISH_KEY;
                ch = 8'($urandom);
            end
            offer_item(op, ch);
            sent++;
        end
        offer_item(OP_END_TEXT, 8'h00);
        s_tvalid <= 1'b0;

        // Wait for every expected result, then keep watching for strays.
        do @(posedge aclk); while (letters_due != 0);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/playfair_pkg.sv
hdl/playfair_datapath.sv
hdl/playfair_ctrl.sv
hdl/playfair_digraph_encryptor.sv
hdl/playfair_checker.sv
tb/playfair_cipher_checker.sv
tb/tb_playfair_digraph_encryptor.sv
